// ===== rtl/tgadec_pkg.sv =====
// Shared types, codes and helpers of the TGA run-length decoder.
// Used by tgadec_hdr_check and tga_rle_decoder_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgadec_pkg;

  // result status codes (out_tuser)
  localparam logic [1:0] ST_PIXEL   = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNELS   = 2'd0;
  localparam logic [1:0] CFG_PIXEL_TOT  = 2'd1;
  localparam logic [1:0] CFG_COMP_BYTES = 2'd2;

  localparam logic [2:0] RST_CHANNELS   = 3'd4;
  localparam logic [31:0] RST_PIXEL_TOT = 32'd1;
  localparam logic [31:0] RST_COMP_BYTES = 32'd1;

  // header evaluation handed to the core
  typedef struct packed {
    logic       is_run;
    logic [7:0] count;     // pixels in packet, 1..128
    logic       short_in;  // no compressed bytes left for this header
    logic       overrun;   // packet does not fit bytes or pixels left
  } hdr_check_t;

  // out-of-range channel counts: 0 acts as 1, 5..7 act as 4
  function automatic logic [2:0] eff_channels(input logic [2:0] ch);
    logic [2:0] r;
    r = ch;
    if (ch == 3'd0) r = 3'd1;
    else if (ch > 3'd4) r = 3'd4;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tga_rle_decoder_core.sv =====
// Top level of the TGA run-length decoder: byte stream in, pixel/run words
// out. Depends on tgadec_pkg and tgadec_hdr_check.
//
// Usage:
//   in_*  : one compressed byte per word (in_tdata[7:0]).
//   out_* : one result per completed pixel or error; out_tdata holds
//           pixel_value [31:0] and repeat_count [39:32], out_tuser the status
//           (pixel, pixel and image complete, packet overrun, input short).
//   cfg_* : register writes (channels, pixel total, compressed length); any
//           write restarts decoding of a new image. cfg_ready is always high.
// Throughput is one byte per cycle unless out_* stalls; each byte is decoded by
// a single level of counter logic between input handshake and output register.
// Latency: a result appears on out_* the cycle after the byte that completes
// it is accepted. Header bytes and non-final pixel bytes give no result.
// A single output register parts the two sides: in_tready stays high while
// that register is empty or being taken, so a stalled receiver stops input
// after one pending result. Once the image is complete or has failed, further
// bytes are accepted and dropped until a register write or reset. Reset loads
// 4 channels, one pixel, one compressed byte and clears all but the out_* data.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] stream_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [31:0] pixel_value, [39:32] repeat_count
  output logic [1:0]       out_tuser,   // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration
  logic [2:0]  channels_r;
  logic [31:0] pixel_tot_r, comp_bytes_r;

  // decode state
  logic        in_body_r, in_body_nxt;
  logic        is_run_r, is_run_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] gather_r, gather_nxt;
  logic [31:0] pix_rem_r, pix_rem_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic        finished_r, finished_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_pix_r;
  logic [7:0]  out_rep_r;
  logic [1:0]  out_st_r;

  logic        emit;
  logic [31:0] emit_pix;
  logic [7:0]  emit_rep;
  logic [1:0]  emit_st;

  logic        in_acc, cfg_acc;
  logic [2:0]  ch_eff;
  logic [31:0] gather_full;
  logic [7:0]  rep;
  logic [31:0] rep_clamp;
  tgadec_pkg::hdr_check_t hdr;

  assign in_tready = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign ch_eff    = tgadec_pkg::eff_channels(channels_r);

  tgadec_hdr_check u_hdr (
    .hdr_byte    (in_tdata),
    .channels    (ch_eff),
    .bytes_left  (bytes_left_r),
    .pixels_left (pix_rem_r),
    .chk         (hdr)
  );

  assign gather_full = gather_r | ({24'd0, in_tdata} << {bip_r, 3'b000});
  assign rep         = is_run_r ? pkt_left_r : 8'd1;
  assign rep_clamp   = ({24'd0, rep} <= pix_rem_r) ? {24'd0, rep} : pix_rem_r;

  always_comb begin
    in_body_nxt    = in_body_r;
    is_run_nxt     = is_run_r;
    pkt_left_nxt   = pkt_left_r;
    bip_nxt        = bip_r;
    gather_nxt     = gather_r;
    pix_rem_nxt    = pix_rem_r;
    bytes_left_nxt = bytes_left_r;
    finished_nxt   = finished_r;
    emit           = 1'b0;
    emit_pix       = 32'd0;
    emit_rep       = 8'd0;
    emit_st        = tgadec_pkg::ST_PIXEL;

    if (in_acc && !finished_r) begin
      if (!in_body_r) begin
        if (hdr.short_in) begin
          finished_nxt = 1'b1;
          emit         = 1'b1;
          emit_st      = tgadec_pkg::ST_SHORT;
        end else begin
          bytes_left_nxt = bytes_left_r - 32'd1;
          if (hdr.overrun) begin
            finished_nxt = 1'b1;
            emit         = 1'b1;
            emit_st      = tgadec_pkg::ST_OVERRUN;
          end else begin
            in_body_nxt  = 1'b1;
            is_run_nxt   = hdr.is_run;
            pkt_left_nxt = hdr.count;
            bip_nxt      = 2'd0;
            gather_nxt   = 32'd0;
          end
        end
      end else begin
        bytes_left_nxt = bytes_left_r - 32'd1;
        if (({1'b0, bip_r} + 3'd1) < ch_eff) begin
          gather_nxt = gather_full;
          bip_nxt    = bip_r + 2'd1;
        end else begin
          pkt_left_nxt = is_run_r ? 8'd0 : pkt_left_r - 8'd1;
          in_body_nxt  = is_run_r ? 1'b0 : (pkt_left_r != 8'd1);
          pix_rem_nxt  = pix_rem_r - rep_clamp;
          bip_nxt      = 2'd0;
          gather_nxt   = 32'd0;
          emit         = 1'b1;
          emit_pix     = gather_full;
          emit_rep     = rep;
          priority if (pix_rem_r == rep_clamp) begin
            emit_st      = tgadec_pkg::ST_DONE;
            finished_nxt = 1'b1;
          end else if (bytes_left_r == 32'd1) begin
            // last declared byte used up with pixels still owed
            emit_st      = tgadec_pkg::ST_SHORT;
            finished_nxt = 1'b1;
          end else begin
            emit_st = tgadec_pkg::ST_PIXEL;
          end
        end
      end
    end

    if (emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r   <= tgadec_pkg::RST_CHANNELS;
      pixel_tot_r  <= tgadec_pkg::RST_PIXEL_TOT;
      comp_bytes_r <= tgadec_pkg::RST_COMP_BYTES;
      in_body_r    <= 1'b0;
      is_run_r     <= 1'b0;
      pkt_left_r   <= 8'd0;
      bip_r        <= 2'd0;
      gather_r     <= 32'd0;
      pix_rem_r    <= tgadec_pkg::RST_PIXEL_TOT;
      bytes_left_r <= tgadec_pkg::RST_COMP_BYTES;
      finished_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_acc && cfg_index <= tgadec_pkg::CFG_COMP_BYTES) begin
        // any register write starts a new image
        in_body_r    <= 1'b0;
        is_run_r     <= 1'b0;
        pkt_left_r   <= 8'd0;
        bip_r        <= 2'd0;
        gather_r     <= 32'd0;
        pix_rem_r    <= pixel_tot_r;
        bytes_left_r <= comp_bytes_r;
        finished_r   <= (pixel_tot_r == 32'd0);
        unique case (cfg_index)
          tgadec_pkg::CFG_CHANNELS: channels_r <= cfg_data[2:0];
          tgadec_pkg::CFG_PIXEL_TOT: begin
            pixel_tot_r <= cfg_data;
            pix_rem_r   <= cfg_data;
            finished_r  <= (cfg_data == 32'd0);
          end
          default: begin
            comp_bytes_r <= cfg_data;
            bytes_left_r <= cfg_data;
          end
        endcase
      end else begin
        in_body_r    <= in_body_nxt;
        is_run_r     <= is_run_nxt;
        pkt_left_r   <= pkt_left_nxt;
        bip_r        <= bip_nxt;
        gather_r     <= gather_nxt;
        pix_rem_r    <= pix_rem_nxt;
        bytes_left_r <= bytes_left_nxt;
        finished_r   <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r <= emit_pix;
      out_rep_r <= emit_rep;
      out_st_r  <= emit_st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rep_r, out_pix_r};
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire

// ===== rtl/tgadec_hdr_check.sv =====
// Packet header evaluation: pixel count and fit checks against the
// bytes and pixels still left. Depends on tgadec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgadec_hdr_check (
  input  wire logic [7:0]  hdr_byte,
  input  wire logic [2:0]  channels,     // already clamped to 1..4
  input  wire logic [31:0] bytes_left,   // compressed bytes not yet consumed
  input  wire logic [31:0] pixels_left,
  output tgadec_pkg::hdr_check_t chk
);

  logic [7:0] count;
  logic [9:0] need;
  logic [9:0] cnt_w;

  // run: header - 127, raw: header + 1; both equal low seven bits + 1
  assign count = {1'b0, hdr_byte[6:0]} + 8'd1;
  assign cnt_w = {2'b00, count};

  always_comb begin
    if (hdr_byte[7]) begin
      need = {7'd0, channels};
    end else begin
      unique case (channels)
        3'd1:    need = cnt_w;
        3'd2:    need = cnt_w << 1;
        3'd3:    need = cnt_w + (cnt_w << 1);
        default: need = cnt_w << 2;
      endcase
    end
  end

  always_comb begin
    chk.is_run   = hdr_byte[7];
    chk.count    = count;
    chk.short_in = (bytes_left == 32'd0);
    // bytes after this header must cover need: need <= bytes_left - 1
    chk.overrun  = ({22'd0, need} >= bytes_left) || ({24'd0, count} > pixels_left);
  end

endmodule

`default_nettype wire
